[rtl/core/mmq_pkg.sv]
// Package for the min/max queue built from two stacks.
// Holds the field widths, operation and status codes, and the command and
// status structs shared by the controller and the datapath. No dependencies.
package mmq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned VALUE_BITS_DEF  = 32;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic    push;
    logic    pop_out;
    logic    xfer_start;
    logic    xfer_step;
    logic    top_from_ram;
    logic    rsp_src_ram;
    logic    load_rsp;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic in_empty;
    logic out_empty;
    logic out_single;
  } stat_t;

endpackage

[rtl/core/mmq_ifs.sv]
// Handshake interfaces for the request and response channels of the queue.
// Depends on mmq_pkg for the field widths.
interface mmq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic signed [mmq_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface mmq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mmq_pkg::VALUE_W-1:0]   min_value;
  logic signed [mmq_pkg::VALUE_W-1:0]   max_value;
  logic        [mmq_pkg::COUNT_W-1:0]   count;
  logic        [mmq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output min_value, output max_value, output count,
                  output status, input ready);
  modport sink (input valid, input min_value, input max_value, input count,
                input status, output ready);
endinterface

[rtl/core/mmq_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mmq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/mmq_ctrl.sv]
// Controller for the min/max queue: sequences pushes, pops and stack moves.
// Depends on mmq_pkg for the command and status structs and the codes.
module mmq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  input  logic           req_op_i,
  output logic           req_ready_o,
  input  logic           rsp_ready_i,
  output logic           rsp_valid_o,
  input  mmq_pkg::stat_t stat_i,
  output mmq_pkg::cmd_t  cmd_o
);
  import mmq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_XFER,
    ST_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e st_q, st_d;
  logic    out_valid_q, out_valid_d;
  logic    rsp_free;
  cmd_t    cmd;

  assign rsp_free = !out_valid_q || rsp_ready_i;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    cmd        = '0;
    cmd.status = st_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          state_d = ST_RESP;
          st_d    = STATUS_OK;
          if (req_op_i == OP_PUSH) begin
            if (stat_i.full) begin
              st_d = STATUS_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end else if (!stat_i.out_empty) begin
            cmd.pop_out = 1'b1;
            if (!stat_i.out_single) begin
              state_d = ST_POP_RD;
            end
          end else if (!stat_i.in_empty) begin
            cmd.xfer_start = 1'b1;
            state_d        = ST_XFER;
          end else begin
            st_d = STATUS_EMPTY;
          end
        end
      end
      ST_POP_RD: begin
        cmd.top_from_ram = 1'b1;
        cmd.rsp_src_ram  = 1'b1;
        if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_d      = ST_IDLE;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_XFER: begin
        // The entry read last is the oldest one once the in stack is drained;
        // it is the value this pop removes, so it is not moved.
        if (!stat_i.in_empty) begin
          cmd.xfer_step = 1'b1;
        end else begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (rsp_free) begin
          cmd.load_rsp = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    out_valid_d = cmd.load_rsp || (out_valid_q && !rsp_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      st_q        <= STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_rsp |-> (!out_valid_q || rsp_ready_i))
    else $error("result register loaded while a result still waits");

  a_xfer_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && req_valid_i && req_op_i == OP_POP && stat_i.out_empty
     && !stat_i.in_empty) |=> (state_q == ST_XFER))
    else $error("pop on an empty out stack did not start a stack move");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> !stat_i.full)
    else $error("push issued while the queue is full");
`endif

endmodule

[rtl/core/mmq_dpath.sv]
// Datapath for the min/max queue: the two stack memories, their depths, the
// cached running min and max of each stack top, and the result register.
// Depends on mmq_pkg and mmq_ram.
module mmq_dpath #(
  parameter int unsigned QUEUE_DEPTH = mmq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = mmq_pkg::VALUE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic signed [mmq_pkg::VALUE_W-1:0]    value_i,
  input  mmq_pkg::cmd_t                         cmd_i,
  output mmq_pkg::stat_t                        stat_o,
  output logic signed [mmq_pkg::VALUE_W-1:0]    min_value_o,
  output logic signed [mmq_pkg::VALUE_W-1:0]    max_value_o,
  output logic        [mmq_pkg::COUNT_W-1:0]    count_o,
  output logic        [mmq_pkg::STATUS_W-1:0]   status_o
);
  import mmq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned VB = VALUE_BITS;

  localparam logic [VB-1:0] VAL_LARGEST  = {1'b0, {(VB - 1){1'b1}}};
  localparam logic [VB-1:0] VAL_SMALLEST = {1'b1, {(VB - 1){1'b0}}};

  logic [CW-1:0] in_depth_q, in_depth_d;
  logic [CW-1:0] out_depth_q, out_depth_d;
  logic [CW:0]   total;
  logic [CW-1:0] in_top_idx, out_below_idx;

  logic signed [VB-1:0] v_in;
  logic signed [VB-1:0] in_min_q, in_min_d, in_max_q, in_max_d;
  logic signed [VB-1:0] out_min_q, out_min_d, out_max_q, out_max_d;
  logic signed [VB-1:0] mv, mv_min, mv_max;
  logic signed [VB-1:0] ram_min, ram_max, cur_min, cur_max, lo, hi;

  logic [VB-1:0]     in_rdata;
  logic [2*VB-1:0]   out_rdata;
  logic              in_re, out_re;

  logic signed [VALUE_W-1:0]  min_q, max_q;
  logic        [COUNT_W-1:0]  count_q;
  logic        [STATUS_W-1:0] status_q;

  assign v_in          = VB'($unsigned(value_i));
  assign total         = {1'b0, in_depth_q} + {1'b0, out_depth_q};
  assign in_top_idx    = in_depth_q - CW'(1);
  assign out_below_idx = out_depth_q - CW'(2);

  assign stat_o.full       = (total >= (CW + 1)'(QUEUE_DEPTH));
  assign stat_o.in_empty   = (in_depth_q == '0);
  assign stat_o.out_empty  = (out_depth_q == '0);
  assign stat_o.out_single = (out_depth_q == CW'(1));

  assign in_re  = cmd_i.xfer_start || cmd_i.xfer_step;
  assign out_re = cmd_i.pop_out && !stat_o.out_single;

  mmq_ram #(
    .WIDTH (VB),
    .DEPTH (QUEUE_DEPTH)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (in_depth_q[AW-1:0]),
    .wdata_i (v_in),
    .re_i    (in_re),
    .raddr_i (in_top_idx[AW-1:0]),
    .rdata_o (in_rdata)
  );

  mmq_ram #(
    .WIDTH (2 * VB),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.xfer_step),
    .waddr_i (out_depth_q[AW-1:0]),
    .wdata_i ({mv_min, mv_max}),
    .re_i    (out_re),
    .raddr_i (out_below_idx[AW-1:0]),
    .rdata_o (out_rdata)
  );

  assign mv      = in_rdata;
  assign ram_min = out_rdata[2*VB-1:VB];
  assign ram_max = out_rdata[VB-1:0];

  always_comb begin
    mv_min = mv;
    mv_max = mv;
    if (out_depth_q != '0) begin
      if (out_min_q < mv) begin
        mv_min = out_min_q;
      end
      if (out_max_q > mv) begin
        mv_max = out_max_q;
      end
    end

    in_min_d = in_min_q;
    in_max_d = in_max_q;
    if (cmd_i.push) begin
      in_min_d = v_in;
      in_max_d = v_in;
      if (in_depth_q != '0) begin
        if (in_min_q < v_in) begin
          in_min_d = in_min_q;
        end
        if (in_max_q > v_in) begin
          in_max_d = in_max_q;
        end
      end
    end

    out_min_d = out_min_q;
    out_max_d = out_max_q;
    if (cmd_i.xfer_step) begin
      out_min_d = mv_min;
      out_max_d = mv_max;
    end else if (cmd_i.top_from_ram) begin
      out_min_d = ram_min;
      out_max_d = ram_max;
    end

    in_depth_d = in_depth_q;
    if (cmd_i.push) begin
      in_depth_d = in_depth_q + CW'(1);
    end else if (in_re) begin
      in_depth_d = in_depth_q - CW'(1);
    end

    out_depth_d = out_depth_q;
    if (cmd_i.xfer_step) begin
      out_depth_d = out_depth_q + CW'(1);
    end else if (cmd_i.pop_out) begin
      out_depth_d = out_depth_q - CW'(1);
    end
  end

  always_comb begin
    cur_min = cmd_i.rsp_src_ram ? ram_min : out_min_q;
    cur_max = cmd_i.rsp_src_ram ? ram_max : out_max_q;
    lo = VAL_LARGEST;
    hi = VAL_SMALLEST;
    if (!stat_o.out_empty && !stat_o.in_empty) begin
      lo = (cur_min < in_min_q) ? cur_min : in_min_q;
      hi = (cur_max > in_max_q) ? cur_max : in_max_q;
    end else if (!stat_o.out_empty) begin
      lo = cur_min;
      hi = cur_max;
    end else if (!stat_o.in_empty) begin
      lo = in_min_q;
      hi = in_max_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_depth_q  <= '0;
      out_depth_q <= '0;
    end else begin
      in_depth_q  <= in_depth_d;
      out_depth_q <= out_depth_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_min_q  <= in_min_d;
    in_max_q  <= in_max_d;
    out_min_q <= out_min_d;
    out_max_q <= out_max_d;
    if (cmd_i.load_rsp) begin
      min_q    <= VALUE_W'(lo);
      max_q    <= VALUE_W'(hi);
      count_q  <= COUNT_W'(total);
      status_q <= cmd_i.status;
    end
  end

  assign min_value_o = min_q;
  assign max_value_o = max_q;
  assign count_o     = count_q;
  assign status_o    = status_q;

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total <= (CW + 1)'(QUEUE_DEPTH))
    else $error("queue holds more entries than its depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_out |-> (out_depth_q != '0))
    else $error("pop from an empty out stack");

  a_move_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.xfer_start || cmd_i.xfer_step) |-> (in_depth_q != '0))
    else $error("stack move read below the bottom of the in stack");
`endif

endmodule

[rtl/core/min_max_queue_two_stacks.sv]
// Top level of the min/max queue built from two stacks.
// Depends on mmq_pkg, mmq_ifs, mmq_ctrl and mmq_dpath.
//
// Usage: each transfer on req_i carries an operation (op 0 pushes value,
// op 1 pops the oldest value). For every accepted request exactly one result
// leaves on rsp_o with the minimum and maximum of the values held after the
// operation, the number of values held and a status (ok, push dropped because
// full, pop ignored because empty). An empty queue reports the largest value
// as minimum and the smallest value as maximum.
// A push, and a pop that finds the out stack non-empty, go from the idle
// state to the response state (or, for a pop that leaves an entry, to the read
// state), and the result is then written to the output register. A pop on an
// empty out stack first moves the in stack over, one entry a cycle through the
// in stack memory read port, and its result is written once the move is done.
// One request is worked on at a time; req_i is ready again once the result
// is written to the output register, so the next request is taken while that
// result waits. If rsp_o stalls, the block holds its next result internally
// and stops accepting requests. Reset empties the queue at once; the stack
// memories are not cleared, since entries above a stack's depth are never read.
module min_max_queue_two_stacks #(
  parameter int unsigned QUEUE_DEPTH = mmq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = mmq_pkg::VALUE_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mmq_req_if.sink    req_i,
  mmq_rsp_if.source  rsp_o
);
  import mmq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  mmq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_ready_o (req_i.ready),
    .rsp_ready_i (rsp_o.ready),
    .rsp_valid_o (rsp_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mmq_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (req_i.value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .min_value_o (rsp_o.min_value),
    .max_value_o (rsp_o.max_value),
    .count_o     (rsp_o.count),
    .status_o    (rsp_o.status)
  );

endmodule

[tb/min_max_queue_two_stacks_checker.sv]
// Checker for the min/max queue: watches the request and response channels,
// predicts every result with its own two-stack queue model and compares.
// Depends on mmq_pkg and the interfaces in mmq_ifs.
module min_max_queue_two_stacks_checker (
  input  logic clk_i,
  input  logic rst_ni,
  mmq_req_if   req_i,
  mmq_rsp_if   rsp_i,
  output int   mismatch_count_o,
  output int   pending_o
);
  import mmq_pkg::*;

  localparam int unsigned DEPTH = QUEUE_DEPTH_DEF;
  localparam logic signed [VALUE_W-1:0] LARGEST  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] SMALLEST = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic signed [VALUE_W-1:0] max_value;
    logic [COUNT_W-1:0]        count;
    status_e                   status;
  } queue_result_t;

  logic signed [VALUE_W-1:0] in_val[DEPTH];
  logic signed [VALUE_W-1:0] in_lo[DEPTH];
  logic signed [VALUE_W-1:0] in_hi[DEPTH];
  logic signed [VALUE_W-1:0] out_val[DEPTH];
  logic signed [VALUE_W-1:0] out_lo[DEPTH];
  logic signed [VALUE_W-1:0] out_hi[DEPTH];
  int in_n = 0;
  int out_n = 0;
  int mismatches = 0;

  queue_result_t pending_results[$];

  assign pending_o        = pending_results.size();
  assign mismatch_count_o = mismatches;

  task automatic stack_entry(input bit to_out, input logic signed [VALUE_W-1:0] v);
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    lo = v;
    hi = v;
    if (to_out) begin
      if (out_n > 0) begin
        if (out_lo[out_n-1] < lo) lo = out_lo[out_n-1];
        if (out_hi[out_n-1] > hi) hi = out_hi[out_n-1];
      end
      out_val[out_n] = v;
      out_lo[out_n] = lo;
      out_hi[out_n] = hi;
      out_n++;
    end else begin
      if (in_n > 0) begin
        if (in_lo[in_n-1] < lo) lo = in_lo[in_n-1];
        if (in_hi[in_n-1] > hi) hi = in_hi[in_n-1];
      end
      in_val[in_n] = v;
      in_lo[in_n] = lo;
      in_hi[in_n] = hi;
      in_n++;
    end
  endtask

  task automatic apply_queue_op(input op_e op, input logic signed [VALUE_W-1:0] value,
                                output queue_result_t res);
    logic signed [VALUE_W-1:0] lo;
    logic signed [VALUE_W-1:0] hi;
    res.status = STATUS_OK;
    if (op == OP_PUSH) begin
      if (in_n + out_n >= DEPTH) res.status = STATUS_FULL;
      else stack_entry(1'b0, value);
    end else begin
      if (out_n == 0) begin
        while (in_n > 0) begin
          in_n--;
          stack_entry(1'b1, in_val[in_n]);
        end
      end
      if (out_n == 0) res.status = STATUS_EMPTY;
      else out_n--;
    end
    lo = LARGEST;
    hi = SMALLEST;
    if (out_n > 0) begin
      if (out_lo[out_n-1] < lo) lo = out_lo[out_n-1];
      if (out_hi[out_n-1] > hi) hi = out_hi[out_n-1];
    end
    if (in_n > 0) begin
      if (in_lo[in_n-1] < lo) lo = in_lo[in_n-1];
      if (in_hi[in_n-1] > hi) hi = in_hi[in_n-1];
    end
    res.min_value = lo;
    res.max_value = hi;
    res.count = COUNT_W'(in_n + out_n);
  endtask

  task automatic report(input string what, input logic [VALUE_W-1:0] got,
                        input logic [VALUE_W-1:0] want);
    $display("%0t: mismatch on %s, got %0h, expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    queue_result_t want;
    queue_result_t next;
    if (rst_ni) begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", VALUE_W'(rsp_i.count), '0);
        end else begin
          want = pending_results.pop_front();
          if (rsp_i.min_value !== want.min_value) begin
            report("min", rsp_i.min_value, want.min_value);
          end
          if (rsp_i.max_value !== want.max_value) begin
            report("max", rsp_i.max_value, want.max_value);
          end
          if (rsp_i.count !== want.count) begin
            report("count", VALUE_W'(rsp_i.count), VALUE_W'(want.count));
          end
          if (rsp_i.status !== want.status) begin
            report("status", VALUE_W'(rsp_i.status), VALUE_W'(want.status));
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        apply_queue_op(op_e'(req_i.op), req_i.value, next);
        pending_results.push_back(next);
      end
    end
  end

endmodule

[tb/min_max_queue_two_stacks_test.sv]
// Top of the min/max queue test: drives directed and random pushes and pops
// with random idle gaps on both channels and gives the verdict.
// Depends on mmq_pkg, mmq_ifs, the queue RTL and the checker module.
module min_max_queue_two_stacks_test;
  import mmq_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam logic signed [VALUE_W-1:0] LARGEST  = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] SMALLEST = {1'b1, {(VALUE_W-1){1'b0}}};

  logic clk_i;
  logic rst_ni;
  bit   calm;
  int   mismatch_count;
  int   pending;

  mmq_req_if req();
  mmq_rsp_if rsp();

  min_max_queue_two_stacks dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  min_max_queue_two_stacks_checker checker_inst (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_i            (req),
    .rsp_i            (rsp),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #8_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    unique case ($urandom_range(0, 9))
      0: return LARGEST;
      1: return SMALLEST;
      2, 3: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(input op_e op, input logic signed [VALUE_W-1:0] value);
    int gap;
    gap = calm ? 0 : gap_length();
    if (gap > 0) begin
      req.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req.valid = 1'b1;
    req.op = op;
    req.value = value;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  initial begin
    int stall;
    rsp.ready = 1'b0;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        rsp.ready = 1'b0;
        stall--;
      end else begin
        rsp.ready = 1'b1;
        if (!calm) stall = gap_length();
      end
    end
  end

  initial begin
    int sent;
    int phase_len;
    int mode;
    int push_pct;
    rst_ni = 1'b0;
    calm = 1'b0;
    req.valid = 1'b0;
    req.op = OP_PUSH;
    req.value = '0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(OP_POP, '0);
    send(OP_PUSH, LARGEST);
    send(OP_PUSH, SMALLEST);
    send(OP_PUSH, '0);
    send(OP_PUSH, -1);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_PUSH, 5);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_PUSH, 7);
    send(OP_PUSH, 3);
    send(OP_PUSH, 9);
    send(OP_POP, '0);
    send(OP_PUSH, -4);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_POP, '0);
    send(OP_POP, '0);
    drain_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 3);
      calm = (mode == 3);
      unique case (mode)
        0: push_pct = 90;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      phase_len = (mode == 0) ? $urandom_range(70, 110) : $urandom_range(20, 80);
      if (phase_len > RANDOM_ITEMS - sent) phase_len = RANDOM_ITEMS - sent;
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct) send(OP_PUSH, random_value());
        else send(OP_POP, random_value());
        sent++;
      end
    end
    calm = 1'b0;
    drain_results();

    if (mismatch_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/mmq_pkg.sv
rtl/core/mmq_ifs.sv
rtl/core/mmq_ram.sv
rtl/core/mmq_ctrl.sv
rtl/core/mmq_dpath.sv
rtl/core/min_max_queue_two_stacks.sv
tb/min_max_queue_two_stacks_checker.sv
tb/min_max_queue_two_stacks_test.sv
